/* design/cfcf_pkg.sv */
// Shared types, constants and the byte-wide CRC-32 update for the frame checker.
// No dependencies; imported by every module of the block.
`default_nettype none

package cfcf_pkg;

  localparam int unsigned MaxChunkDataDefault = 192;

  localparam logic [31:0] CrcPoly = 32'hEDB8_8320;
  localparam logic [31:0] CrcInit = 32'hFFFF_FFFF;

  localparam logic [7:0] MagicFirstReset  = 8'hDC;
  localparam logic [7:0] MagicSecondReset = 8'h6E;

  localparam logic [7:0] HeaderBytes  = 8'd6;
  localparam logic [7:0] TrailerBytes = 8'd4;
  localparam logic [7:0] MinFrame     = HeaderBytes + TrailerBytes;
  localparam logic [7:0] CountMax     = 8'hFF;

  localparam logic [7:0] PosMagicFirst  = 8'd0;
  localparam logic [7:0] PosMagicSecond = 8'd1;
  localparam logic [7:0] PosKind        = 8'd2;
  localparam logic [7:0] PosSeq         = 8'd3;
  localparam logic [7:0] PosTotal       = 8'd4;
  localparam logic [7:0] PosLength      = 8'd5;

  localparam logic REG_MAGIC_FIRST  = 1'b0;
  localparam logic REG_MAGIC_SECOND = 1'b1;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_BAD = 2'd1;
  localparam logic [1:0] ST_CRC = 2'd2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_burst;
  } beat_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic [1:0] frame_status;
    logic [7:0] frame_kind;
    logic [7:0] seq_number;
    logic [7:0] chunk_total;
    logic [7:0] payload_length;
  } result_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int j = 0; j < 8; j++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* design/cfcf_in_reg.sv */
// Input register stage of the frame checker: holds one accepted beat.
// Depends on cfcf_pkg for the beat type.
`default_nettype none

module cfcf_in_reg (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire cfcf_pkg::beat_t in_beat,
  input  wire logic           take,
  output logic                s1_valid,
  output cfcf_pkg::beat_t     s1_beat
);
  import cfcf_pkg::*;

  assign in_stall = s1_valid && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_beat <= in_beat;
    end
  end

endmodule

`default_nettype wire

/* design/cfcf_frame_core.sv */
// Frame state, configuration registers and per-beat check logic.
// Depends on cfcf_pkg for types, status codes and the CRC update.
`default_nettype none

module cfcf_frame_core #(
  parameter int unsigned MAX_CHUNK_DATA = cfcf_pkg::MaxChunkDataDefault
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_write,
  input  wire logic            cfg_index,
  input  wire logic [7:0]      cfg_data,
  input  wire logic            take,
  input  wire cfcf_pkg::beat_t s1_beat,
  output logic                 res_valid,
  output cfcf_pkg::result_t    res
);
  import cfcf_pkg::*;

  localparam logic [7:0] MaxLen   = 8'(MAX_CHUNK_DATA);
  localparam logic [7:0] MaxBurst = 8'(MAX_CHUNK_DATA + 10);

  logic [7:0]  magic_first;
  logic [7:0]  magic_second;
  logic [7:0]  byte_count;
  logic [31:0] crc_accum;
  logic [31:0] trailer_shift;
  logic        magic_good;
  logic [7:0]  hdr_kind;
  logic [7:0]  hdr_seq;
  logic [7:0]  hdr_total;
  logic [7:0]  hdr_length;

  logic [7:0]  byte_count_next;
  logic [31:0] crc_accum_next;
  logic [31:0] trailer_shift_next;
  logic        magic_good_next;
  logic [7:0]  hdr_kind_next;
  logic [7:0]  hdr_seq_next;
  logic [7:0]  hdr_total_next;
  logic [7:0]  hdr_length_next;

  logic [7:0]  b;
  logic        in_body;
  logic        bad;
  logic        fwd;

  assign b = s1_beat.in_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      magic_first  <= MagicFirstReset;
      magic_second <= MagicSecondReset;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MAGIC_FIRST:  magic_first  <= cfg_data;
        REG_MAGIC_SECOND: magic_second <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    magic_good_next = magic_good;
    hdr_kind_next   = hdr_kind;
    hdr_seq_next    = hdr_seq;
    hdr_total_next  = hdr_total;
    hdr_length_next = hdr_length;
    unique case (byte_count)
      PosMagicFirst:  if (b != magic_first) magic_good_next = 1'b0;
      PosMagicSecond: if (b != magic_second) magic_good_next = 1'b0;
      PosKind:        hdr_kind_next = b;
      PosSeq:         hdr_seq_next = b;
      PosTotal:       hdr_total_next = b;
      PosLength:      hdr_length_next = b;
      default: ;
    endcase

    in_body = {1'b0, byte_count} < ({1'b0, HeaderBytes} + {1'b0, hdr_length_next});
    crc_accum_next     = in_body ? crc_byte(crc_accum, b) : crc_accum;
    trailer_shift_next = {trailer_shift[23:0], b};
    byte_count_next    = (byte_count == CountMax) ? CountMax : byte_count + 8'd1;

    bad = (byte_count_next < MinFrame) || (byte_count_next > MaxBurst) || !magic_good_next
       || ({1'b0, byte_count_next} != ({1'b0, MinFrame} + {1'b0, hdr_length_next}));
    fwd = (byte_count >= HeaderBytes) && in_body && magic_good_next
       && (hdr_length_next <= MaxLen);

    res = '0;
    if (s1_beat.end_of_burst) begin
      res.result_kind    = KIND_STATUS;
      res.frame_status   = bad ? ST_BAD : ((~crc_accum_next != trailer_shift_next) ? ST_CRC : ST_OK);
      res.frame_kind     = hdr_kind_next;
      res.seq_number     = hdr_seq_next;
      res.chunk_total    = hdr_total_next;
      res.payload_length = hdr_length_next;
    end else begin
      res.result_kind   = KIND_PAYLOAD;
      res.payload_byte  = b;
      res.payload_index = byte_count - HeaderBytes;
    end
    res_valid = s1_beat.end_of_burst || fwd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count    <= '0;
      crc_accum     <= CrcInit;
      trailer_shift <= '0;
      magic_good    <= 1'b1;
      hdr_kind      <= '0;
      hdr_seq       <= '0;
      hdr_total     <= '0;
      hdr_length    <= '0;
    end else if (take) begin
      if (s1_beat.end_of_burst) begin
        byte_count    <= '0;
        crc_accum     <= CrcInit;
        trailer_shift <= '0;
        magic_good    <= 1'b1;
        hdr_kind      <= '0;
        hdr_seq       <= '0;
        hdr_total     <= '0;
        hdr_length    <= '0;
      end else begin
        byte_count    <= byte_count_next;
        crc_accum     <= crc_accum_next;
        trailer_shift <= trailer_shift_next;
        magic_good    <= magic_good_next;
        hdr_kind      <= hdr_kind_next;
        hdr_seq       <= hdr_seq_next;
        hdr_total     <= hdr_total_next;
        hdr_length    <= hdr_length_next;
      end
    end
  end

endmodule

`default_nettype wire

/* design/cfcf_out_reg.sv */
// Result register of the frame checker: holds one result beat until taken.
// Depends on cfcf_pkg for the result type.
`default_nettype none

module cfcf_out_reg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s1_valid,
  input  wire logic              res_valid,
  input  wire cfcf_pkg::result_t res,
  output logic                   take,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output cfcf_pkg::result_t      out_res
);
  import cfcf_pkg::*;

  assign take = s1_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= res_valid;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res_valid) begin
      out_res <= res;
    end
  end

endmodule

`default_nettype wire

/* design/crc32_chunk_frame_checker_top.sv */
// A result beat passes the input register and then the result register before it is valid at the outputs.
// Throughput: one input beat per cycle while the output is not stalled; the CRC update is byte-wide.
// A stalled output holds its beat while one more input beat waits in the input register.
// Reset (rst, synchronous, active high) clears the burst state and loads the magic
// registers with their defaults.
// Depends on cfcf_pkg, cfcf_in_reg, cfcf_frame_core and cfcf_out_reg.
`default_nettype none

module crc32_chunk_frame_checker_top #(
  parameter int unsigned MAX_CHUNK_DATA = cfcf_pkg::MaxChunkDataDefault
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_write,
  input  wire logic       cfg_index,
  input  wire logic [7:0] cfg_data,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  input  wire logic       end_of_burst,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            result_kind,
  output logic [7:0]      payload_byte,
  output logic [7:0]      payload_index,
  output logic [1:0]      frame_status,
  output logic [7:0]      frame_kind,
  output logic [7:0]      seq_number,
  output logic [7:0]      chunk_total,
  output logic [7:0]      payload_length
);
  import cfcf_pkg::*;

  beat_t   in_beat;
  beat_t   s1_beat;
  logic    s1_valid;
  logic    take;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign in_beat.in_byte      = in_byte;
  assign in_beat.end_of_burst = end_of_burst;

  cfcf_in_reg u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_beat  (in_beat),
    .take     (take),
    .s1_valid (s1_valid),
    .s1_beat  (s1_beat)
  );

  cfcf_frame_core #(
    .MAX_CHUNK_DATA (MAX_CHUNK_DATA)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .take      (take),
    .s1_beat   (s1_beat),
    .res_valid (res_valid),
    .res       (res)
  );

  cfcf_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .s1_valid  (s1_valid),
    .res_valid (res_valid),
    .res       (res),
    .take      (take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign result_kind    = out_res.result_kind;
  assign payload_byte   = out_res.payload_byte;
  assign payload_index  = out_res.payload_index;
  assign frame_status   = out_res.frame_status;
  assign frame_kind     = out_res.frame_kind;
  assign seq_number     = out_res.seq_number;
  assign chunk_total    = out_res.chunk_total;
  assign payload_length = out_res.payload_length;

endmodule

`default_nettype wire

/* design/cfcf_checker.sv */
// Port-level checks for the frame checker top level, and the bind that attaches them.
// Depends on cfcf_pkg for result kinds and status codes.
`default_nettype none

module cfcf_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic       result_kind,
  input wire logic [7:0] payload_byte,
  input wire logic [7:0] payload_index,
  input wire logic [1:0] frame_status,
  input wire logic [7:0] frame_kind,
  input wire logic [7:0] seq_number,
  input wire logic [7:0] chunk_total,
  input wire logic [7:0] payload_length
);
  import cfcf_pkg::*;

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid && !in_stall)
    else $error("outputs not idle after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result_kind) && $stable(payload_byte)
      && $stable(payload_index) && $stable(frame_status))
    else $error("stalled result beat changed");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == KIND_STATUS |->
      (frame_status == ST_OK || frame_status == ST_BAD || frame_status == ST_CRC)
      && payload_byte == 8'd0 && payload_index == 8'd0)
    else $error("malformed status beat");

  a_payload_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == KIND_PAYLOAD |->
      frame_status == ST_OK && frame_kind == 8'd0 && seq_number == 8'd0
      && chunk_total == 8'd0 && payload_length == 8'd0)
    else $error("payload beat carries header fields");

endmodule

bind crc32_chunk_frame_checker_top cfcf_checker u_cfcf_checker (.*);

`default_nettype wire
